FILE: rtl/core/fltpe_pkg.sv
// Shared types and constants for the four-level page-table engine.
package fltpe_pkg;

  typedef enum logic [1:0] {
    ACT_MAP4K   = 2'd0,
    ACT_UNMAP4K = 2'd1,
    ACT_XLATE   = 2'd2,
    ACT_MAP2M   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ALIGN  = 2'd1,
    ST_NOMEM  = 2'd2,
    ST_NOTMAP = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_CLR,
    WR_LINK,
    WR_LEAF,
    WR_UNMAP
  } wr_sel_t;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_START,
    S_READ,
    S_EVAL,
    S_ZERO,
    S_LINK,
    S_DONE
  } state_t;

  localparam logic [1:0] CFG_TABLE_BASE = 2'd0;
  localparam logic [1:0] CFG_FLAG_MASK  = 2'd1;

  localparam logic [51:0] TableBaseReset = 52'd1048576;
  localparam logic [11:0] FlagMaskReset  = 12'd4094;
  localparam logic [11:0] EntryPresent   = 12'h001;
  localparam logic [11:0] EntryWrite     = 12'h002;
  localparam logic [11:0] EntryHuge      = 12'h080;

  typedef struct packed {
    logic    load;
    logic    rd;
    wr_sel_t wr;
    logic    alloc;
    logic    cnt_inc;
    logic    descend;
    logic    descend_new;
    logic    set_res;
    status_t code;
    logic    take_result;
    logic    finish;
  } cmd_t;

  typedef struct packed {
    logic       present;
    logic       huge;
    logic       follow_ok;
    logic       full;
    logic       cnt_last;
    logic [1:0] lvl;
    action_t    action;
    logic       misaligned;
    logic       out_free;
  } stat_t;

endpackage

FILE: rtl/core/fltpe_datapath.sv
// Datapath: request registers, table store, allocator, walk state and result register.
module fltpe_datapath #(
  parameter int FRAMES = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  fltpe_pkg::cmd_t     cmd,
  output fltpe_pkg::stat_t    stat,
  input  logic                cfg_valid,
  input  logic                cfg_index,
  input  logic [51:0]         cfg_data,
  input  logic [1:0]          action,
  input  logic [47:0]         virt_addr,
  input  logic [51:0]         phys_addr,
  input  logic [11:0]         low_flags,
  input  logic                no_execute,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          status,
  output logic [51:0]         phys_out
);

  localparam int FW = $clog2(FRAMES);
  localparam int AW = FW + 9;
  localparam int DEPTH = FRAMES * 512;
  localparam logic [13:0] FramesW = 14'(FRAMES);

  logic [63:0] mem [DEPTH];
  logic [63:0] q;

  logic [51:0] table_base;
  logic [11:0] flag_mask;

  fltpe_pkg::action_t act;
  logic [47:0] virt;
  logic [51:0] phys;
  logic [11:0] fl;
  logic        nx;
  logic [1:0]  lvl;
  logic [FW-1:0] frame;
  logic [FW-1:0] new_frame;
  logic [12:0] next_free;
  logic [8:0]  cnt;
  fltpe_pkg::status_t pend_status;
  logic [51:0] pend_phys;

  logic [8:0]  idx;
  logic [AW-1:0] addr;
  logic [AW-1:0] waddr;
  logic [63:0] wdata;
  logic [39:0] off;
  logic [39:0] link_pfn;
  logic [11:0] leaf_low;

  function automatic logic [11:0] fluent_huge();
    return fltpe_pkg::EntryPresent |
           ((act == fltpe_pkg::ACT_MAP2M) ? fltpe_pkg::EntryHuge : 12'h000);
  endfunction

  always_comb begin
    case (lvl)
      2'd3:    idx = virt[47:39];
      2'd2:    idx = virt[38:30];
      2'd1:    idx = virt[29:21];
      default: idx = virt[20:12];
    endcase
  end

  assign addr     = {frame, idx};
  assign off      = q[51:12] - table_base[51:12];
  assign link_pfn = table_base[51:12] + 40'(new_frame);
  assign leaf_low = fl | fluent_huge();

  always_comb begin
    waddr = addr;
    wdata = 64'd0;
    case (cmd.wr)
      fltpe_pkg::WR_CLR:  waddr = {new_frame, cnt};
      fltpe_pkg::WR_LINK: wdata = {12'd0, link_pfn,
                                   fltpe_pkg::EntryPresent | fltpe_pkg::EntryWrite};
      fltpe_pkg::WR_LEAF: wdata = {nx, 11'd0, phys[51:12], leaf_low};
      default:            wdata = 64'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr != fltpe_pkg::WR_NONE) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd) begin
      q <= mem[addr];
    end
  end

  // Request capture and walk position
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act   <= fltpe_pkg::action_t'(action);
      virt  <= virt_addr;
      phys  <= phys_addr;
      fl    <= low_flags & flag_mask;
      nx    <= no_execute;
      lvl   <= 2'd3;
      frame <= '0;
    end else if (cmd.descend) begin
      lvl   <= lvl - 2'd1;
      frame <= off[FW-1:0];
    end else if (cmd.descend_new) begin
      lvl   <= lvl - 2'd1;
      frame <= new_frame;
    end
    if (cmd.set_res) begin
      pend_status <= cmd.code;
      if (!cmd.take_result) begin
        pend_phys <= 52'd0;
      end else if (lvl == 2'd1) begin
        // 2 MiB leaf: entry address bits ORed with the offset bits
        pend_phys <= {q[51:21], q[20:12] | virt[20:12], virt[11:0]};
      end else begin
        pend_phys <= {q[51:12], virt[11:0]};
      end
    end
    if (cmd.finish) begin
      status   <= pend_status;
      phys_out <= pend_phys;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_base <= fltpe_pkg::TableBaseReset;
      flag_mask  <= fltpe_pkg::FlagMaskReset;
      next_free  <= 13'd1;
      new_frame  <= '0;
      cnt        <= 9'd0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if ({1'b0, cfg_index} == fltpe_pkg::CFG_TABLE_BASE) begin
          table_base <= cfg_data;
        end else begin
          flag_mask <= cfg_data[11:0];
        end
      end
      if (cmd.alloc) begin
        new_frame <= next_free[FW-1:0];
        next_free <= next_free + 13'd1;
        cnt       <= 9'd0;
      end else if (cmd.cnt_inc) begin
        cnt <= cnt + 9'd1;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.present   = q[0];
    stat.huge      = q[7];
    stat.follow_ok = off < 40'(next_free);
    stat.full      = {1'b0, next_free} >= FramesW;
    stat.cnt_last  = (cnt == 9'd511);
    stat.lvl       = lvl;
    stat.action    = act;
    stat.out_free  = !out_valid || out_ready;
    if (act == fltpe_pkg::ACT_MAP2M) begin
      stat.misaligned = (phys[20:0] != 21'd0) || (virt[20:0] != 21'd0);
    end else begin
      stat.misaligned = (phys[11:0] != 12'd0) || (virt[11:0] != 12'd0);
    end
  end

endmodule

FILE: rtl/core/fltpe_ctrl.sv
// Controller: sequences reset clear, walk, table allocation and result hand-off.
module fltpe_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  fltpe_pkg::stat_t stat,
  output fltpe_pkg::cmd_t  cmd
);

  fltpe_pkg::state_t state, state_next;
  logic is_map, leaf_here, is_xlate;

  assign is_map = (stat.action == fltpe_pkg::ACT_MAP4K) ||
                  (stat.action == fltpe_pkg::ACT_MAP2M);
  assign is_xlate = (stat.action == fltpe_pkg::ACT_XLATE);
  assign leaf_here = ((stat.action == fltpe_pkg::ACT_MAP4K) && (stat.lvl == 2'd0)) ||
                     ((stat.action == fltpe_pkg::ACT_MAP2M) && (stat.lvl == 2'd1));
  assign in_ready = (state == fltpe_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fltpe_pkg::S_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      fltpe_pkg::S_CLR:   if (stat.cnt_last) state_next = fltpe_pkg::S_IDLE;
      fltpe_pkg::S_IDLE:  if (in_valid) state_next = fltpe_pkg::S_START;
      fltpe_pkg::S_START: begin
        state_next = stat.misaligned && is_map ? fltpe_pkg::S_DONE : fltpe_pkg::S_READ;
      end
      fltpe_pkg::S_READ:  state_next = fltpe_pkg::S_EVAL;
      fltpe_pkg::S_EVAL: begin
        if (is_map) begin
          if (leaf_here) begin
            state_next = fltpe_pkg::S_DONE;
          end else if (stat.present) begin
            state_next = (!stat.huge && stat.follow_ok) ? fltpe_pkg::S_READ
                                                         : fltpe_pkg::S_DONE;
          end else begin
            state_next = stat.full ? fltpe_pkg::S_DONE : fltpe_pkg::S_ZERO;
          end
        end else if (stat.lvl == 2'd0) begin
          state_next = fltpe_pkg::S_DONE;
        end else if (stat.lvl == 2'd1 && stat.present && stat.huge) begin
          state_next = fltpe_pkg::S_DONE;
        end else begin
          state_next = (stat.present && stat.follow_ok) ? fltpe_pkg::S_READ
                                                        : fltpe_pkg::S_DONE;
        end
      end
      fltpe_pkg::S_ZERO:  if (stat.cnt_last) state_next = fltpe_pkg::S_LINK;
      fltpe_pkg::S_LINK:  state_next = fltpe_pkg::S_READ;
      fltpe_pkg::S_DONE:  if (stat.out_free) state_next = fltpe_pkg::S_IDLE;
      default:            state_next = fltpe_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.wr = fltpe_pkg::WR_NONE;
    cmd.code = fltpe_pkg::ST_OK;
    case (state)
      fltpe_pkg::S_CLR: begin
        cmd.wr = fltpe_pkg::WR_CLR;
        cmd.cnt_inc = 1'b1;
      end
      fltpe_pkg::S_IDLE: cmd.load = in_valid;
      fltpe_pkg::S_START: begin
        if (stat.misaligned && is_map) begin
          cmd.set_res = 1'b1;
          cmd.code = fltpe_pkg::ST_ALIGN;
        end
      end
      fltpe_pkg::S_READ: cmd.rd = 1'b1;
      fltpe_pkg::S_EVAL: begin
        if (is_map) begin
          if (leaf_here) begin
            cmd.wr = fltpe_pkg::WR_LEAF;
            cmd.set_res = 1'b1;
          end else if (stat.present) begin
            if (!stat.huge && stat.follow_ok) begin
              cmd.descend = 1'b1;
            end else begin
              cmd.set_res = 1'b1;
              cmd.code = fltpe_pkg::ST_NOMEM;
            end
          end else if (stat.full) begin
            cmd.set_res = 1'b1;
            cmd.code = fltpe_pkg::ST_NOMEM;
          end else begin
            cmd.alloc = 1'b1;
          end
        end else if (stat.lvl == 2'd0) begin
          if (stat.action == fltpe_pkg::ACT_UNMAP4K) cmd.wr = fltpe_pkg::WR_UNMAP;
          cmd.set_res = 1'b1;
          cmd.code = stat.present ? fltpe_pkg::ST_OK : fltpe_pkg::ST_NOTMAP;
          cmd.take_result = stat.present && is_xlate;
        end else if (stat.lvl == 2'd1 && stat.present && stat.huge) begin
          cmd.set_res = 1'b1;
          cmd.take_result = is_xlate;
          cmd.code = is_xlate ? fltpe_pkg::ST_OK : fltpe_pkg::ST_NOTMAP;
        end else if (stat.present && stat.follow_ok) begin
          cmd.descend = 1'b1;
        end else begin
          cmd.set_res = 1'b1;
          cmd.code = fltpe_pkg::ST_NOTMAP;
        end
      end
      fltpe_pkg::S_ZERO: begin
        cmd.wr = fltpe_pkg::WR_CLR;
        cmd.cnt_inc = 1'b1;
      end
      fltpe_pkg::S_LINK: begin
        cmd.wr = fltpe_pkg::WR_LINK;
        cmd.descend_new = 1'b1;
      end
      fltpe_pkg::S_DONE: cmd.finish = stat.out_free;
      default: cmd.wr = fltpe_pkg::WR_NONE;
    endcase
  end

endmodule

FILE: rtl/core/four_level_page_table_engine.sv
// Top level of the four-level page-table engine: controller plus datapath.
//
// Keeps an x86-64 style four-level page-table tree in an on-chip store of
// FRAMES 4 KiB frames (512 x 64-bit entries each, one read and one write port,
// registered read). Frame 0 is the root table. After reset the block clears
// the root frame and holds in_ready low meanwhile; configuration writes are
// taken at any time (cfg_ready is tied high) but must only be issued while the
// block is idle. One item is worked at a time. Each item is accepted and
// checked for alignment, then each table level is read (up to four levels);
// for each intermediate table that a map allocates, all 512 entries are cleared
// and the link is written; then the result is posted. A misaligned map skips
// the reads. The result sits in an output register, so the next item can be
// accepted while it waits for out_ready.
module four_level_page_table_engine #(
  parameter int FRAMES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [51:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [47:0] virt_addr,
  input  logic [51:0] phys_addr,
  input  logic [11:0] low_flags,
  input  logic        no_execute,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [51:0] phys_out
);

  fltpe_pkg::cmd_t  cmd;
  fltpe_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  // Sequencer: reset clear, level walk, allocation, result hand-off
  fltpe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Table store, bump allocator, entry decode and result register
  fltpe_datapath #(
    .FRAMES (FRAMES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .action     (action),
    .virt_addr  (virt_addr),
    .phys_addr  (phys_addr),
    .low_flags  (low_flags),
    .no_execute (no_execute),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .phys_out   (phys_out)
  );

endmodule

FILE: rtl/core/fltpe_checker.sv
// Port-level checker for the page-table engine and its bind.
module fltpe_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [51:0] phys_out
);

  // A held result does not change
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(phys_out))
    else $error("result changed while stalled");

  // Only a successful translate carries an address
  a_zero_phys: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != fltpe_pkg::ST_OK) |-> phys_out == 52'd0)
    else $error("nonzero address on failed item");

  // One item in flight: accepting drops ready
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted during work");

endmodule

bind four_level_page_table_engine fltpe_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .status    (status),
  .phys_out  (phys_out)
);
